// ===== design/gem_rle_pkg.sv =====
// Shared types and constants for the GEM IMG scanline run-length encoder.
// No dependencies; imported by gem_img_scanline_rle_encoder_unit, rle_stream_checker and testbench.
package gem_rle_pkg;

  localparam int LINE_BYTES_MAX_DEF = 256;

  // Run and record limits of the GEM IMG scanline format
  localparam logic [6:0] RUN_MAX    = 7'd127;
  localparam logic [7:0] LIT_TAG    = 8'h80;
  localparam logic [7:0] SOLID_ZERO = 8'h00;
  localparam logic [7:0] SOLID_ONES = 8'hFF;
  localparam logic [7:0] PAT_TAG    = 8'h00;
  localparam int         SOLID_MIN  = 3;
  localparam int         PAT_MIN    = 6;

  // Request opcodes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       last_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_line;
    logic       nothing_ready;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_PEND,
    ST_FETCH,
    ST_TOP,
    ST_C1,
    ST_C2,
    ST_CMP,
    ST_EVAL,
    ST_LIT_HDR,
    ST_LIT_CNT,
    ST_LIT_RD,
    ST_LIT_WR,
    ST_RUN_SOLID,
    ST_PAT_0,
    ST_PAT_N,
    ST_PAT_C1,
    ST_PAT_C2
  } state_t;

endpackage

// ===== design/gem_img_scanline_rle_encoder_unit.sv =====
// GEM IMG scanline run-length encoder: line store, coded store and encode sequencer.
// Depends on gem_rle_pkg.

// A push request writes the byte into the line store. The push flagged as last starts the
// encoder, which walks the line store through its single read port and writes the coded
// line into a coded store; the block takes no request until it is done. Every start
// position is tried in turn: the bytes from it on are read and compared to rule out or
// find a run. A byte that starts no run is later copied as a literal behind a record
// header of tag and count; a run is written as its record bytes. A fetch request then
// goes through a coded store read and an output register load; a fetch with nothing
// pending loads the output register directly. A request is taken while a response still
// waits only if that response is being taken in the same cycle. A push that arrives
// while coded bytes are pending drops them and starts a new line; bytes beyond
// LINE_BYTES_MAX are dropped.
module gem_img_scanline_rle_encoder_unit
  import gem_rle_pkg::*;
#(
  parameter int LINE_BYTES_MAX = LINE_BYTES_MAX_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int CODED_MAX = LINE_BYTES_MAX + 2 * (LINE_BYTES_MAX / 127) + 8;
  localparam int LW  = $clog2(LINE_BYTES_MAX + 1);
  localparam int IW  = $clog2(LINE_BYTES_MAX);
  localparam int CW  = $clog2(CODED_MAX + 1);
  localparam int CIW = $clog2(CODED_MAX);
  localparam int XW  = LW + 8;

  state_t state, state_next;

  logic [LW-1:0] len, len_next;
  logic [LW-1:0] p, p_next;
  logic [LW-1:0] start, start_next;
  logic [LW-1:0] cnt, cnt_next;
  logic [LW-1:0] rem, rem_next;
  logic [6:0]    k, k_next;
  logic [7:0]    c1, c1_next;
  logic [7:0]    c2, c2_next;
  logic          is_pat, is_pat_next;
  logic          is_zero, is_zero_next;
  logic          run_pending, run_pending_next;
  logic [CW-1:0] wr, wr_next;
  logic [CW-1:0] rd, rd_next;
  logic          rsp_valid_next;
  rsp_t          rsp_next;

  logic [7:0] line_mem [LINE_BYTES_MAX];
  logic [7:0] coded_mem [CODED_MAX];
  logic [7:0] ls_q;
  logic [7:0] cd_q;

  logic          ls_we;
  logic [IW-1:0] ls_waddr;
  logic [IW-1:0] ls_raddr;
  logic          cd_we;
  logic [7:0]    cd_wdata;

  logic          accept;
  logic [LW-1:0] base_len;
  logic [LW:0]   p1, p2, scan_idx;
  logic [LW-1:0] lit_left;
  logic [6:0]    lit_chunk;
  logic          rem_big;
  logic [6:0]    rem_chunk;
  logic [LW-1:0] p_pat;
  logic          is_solid;
  logic          run_ok;
  logic          eol;
  logic          room;
  logic [7:0]    cmp_ref;

  assign accept   = req_valid && req_ready;
  assign base_len = (state == ST_PEND) ? '0 : len;
  assign p1       = {1'b0, p} + 1'b1;
  assign p2       = {1'b0, p} + 2'd2;
  assign scan_idx = {1'b0, p} + {1'b0, cnt} + 1'b1;
  assign lit_left = p - start;
  assign lit_chunk = (XW'(lit_left) > XW'(RUN_MAX)) ? RUN_MAX : 7'(XW'(lit_left));
  assign rem_big   = XW'(rem) > XW'(RUN_MAX);
  assign rem_chunk = rem_big ? RUN_MAX : 7'(XW'(rem));
  assign p_pat     = LW'(XW'(p) + XW'({rem_chunk, 1'b0}));
  assign is_solid  = ((c1 == SOLID_ZERO) || (c1 == SOLID_ONES)) && (c2 == c1);
  // Solid runs count from three bytes; pair patterns need an even length of six or more
  assign run_ok    = (XW'(cnt) >= XW'(SOLID_MIN)) && (is_solid || (XW'(cnt) >= XW'(PAT_MIN)));
  assign eol       = (rd + 1'b1) == wr;
  assign room      = XW'(wr) < XW'(CODED_MAX);
  assign cmp_ref   = cnt[0] ? c2 : c1;
  assign ls_waddr  = base_len[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      len         <= '0;
      p           <= '0;
      start       <= '0;
      run_pending <= 1'b0;
      wr          <= '0;
      rd          <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      len         <= len_next;
      p           <= p_next;
      start       <= start_next;
      run_pending <= run_pending_next;
      wr          <= wr_next;
      rd          <= rd_next;
      rsp_valid   <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt     <= cnt_next;
    rem     <= rem_next;
    k       <= k_next;
    c1      <= c1_next;
    c2      <= c2_next;
    is_pat  <= is_pat_next;
    is_zero <= is_zero_next;
    rsp     <= rsp_next;
  end

  always_ff @(posedge clk) begin
    if (ls_we) begin
      line_mem[ls_waddr] <= req.data_byte;
    end
    ls_q <= line_mem[ls_raddr];
  end

  always_ff @(posedge clk) begin
    if (cd_we) begin
      coded_mem[wr[CIW-1:0]] <= cd_wdata;
    end
    cd_q <= coded_mem[rd[CIW-1:0]];
  end

  always_comb begin
    state_next       = state;
    len_next         = len;
    p_next           = p;
    start_next       = start;
    cnt_next         = cnt;
    rem_next         = rem;
    k_next           = k;
    c1_next          = c1;
    c2_next          = c2;
    is_pat_next      = is_pat;
    is_zero_next     = is_zero;
    run_pending_next = run_pending;
    wr_next          = wr;
    rd_next          = rd;
    rsp_valid_next   = rsp_valid && !rsp_ready;
    rsp_next         = rsp;
    ls_we            = 1'b0;
    ls_raddr         = '0;
    cd_we            = 1'b0;
    cd_wdata         = '0;
    req_ready        = ((state == ST_LOAD) || (state == ST_PEND)) && (!rsp_valid || rsp_ready);

    unique case (state) inside
      ST_LOAD, ST_PEND: begin
        if (accept) begin
          if (req.op == OP_PUSH) begin
            // A push while coded bytes wait drops them and opens a new line
            wr_next = '0;
            rd_next = '0;
            if (XW'(base_len) < XW'(LINE_BYTES_MAX)) begin
              ls_we    = 1'b1;
              len_next = base_len + 1'b1;
            end else begin
              len_next = base_len;
            end
            if (req.last_byte) begin
              p_next           = '0;
              start_next       = '0;
              run_pending_next = 1'b0;
              state_next       = ST_TOP;
            end else begin
              state_next = ST_LOAD;
            end
          end else if (state == ST_LOAD) begin
            rsp_valid_next = 1'b1;
            rsp_next       = '{out_byte: 8'h00, end_of_line: 1'b0, nothing_ready: 1'b1};
          end else begin
            state_next = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        rsp_valid_next = 1'b1;
        rsp_next       = '{out_byte: cd_q, end_of_line: eol, nothing_ready: 1'b0};
        rd_next        = rd + 1'b1;
        if (eol) begin
          len_next   = '0;
          wr_next    = '0;
          rd_next    = '0;
          state_next = ST_LOAD;
        end else begin
          state_next = ST_PEND;
        end
      end
      ST_TOP: begin
        if (XW'(p) >= XW'(len)) begin
          run_pending_next = 1'b0;
          state_next = (start != p) ? ST_LIT_HDR : ST_PEND;
        end else begin
          ls_raddr   = p[IW-1:0];
          state_next = ST_C1;
        end
      end
      ST_C1: begin
        c1_next = ls_q;
        if (p1 < {1'b0, len}) begin
          ls_raddr   = p1[IW-1:0];
          state_next = ST_C2;
        end else begin
          p_next     = p + 1'b1;
          state_next = ST_TOP;
        end
      end
      ST_C2: begin
        c2_next  = ls_q;
        cnt_next = LW'(2);
        if (p2 < {1'b0, len}) begin
          ls_raddr   = p2[IW-1:0];
          state_next = ST_CMP;
        end else begin
          p_next     = p + 1'b1;
          state_next = ST_TOP;
        end
      end
      ST_CMP: begin
        // Even offsets match the first byte, odd offsets the second
        if (ls_q == cmp_ref) begin
          cnt_next = cnt + 1'b1;
          if (scan_idx < {1'b0, len}) begin
            ls_raddr = scan_idx[IW-1:0];
          end else begin
            state_next = ST_EVAL;
          end
        end else begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!run_ok) begin
          p_next     = p + 1'b1;
          state_next = ST_TOP;
        end else begin
          is_pat_next  = !is_solid;
          is_zero_next = (c1 == SOLID_ZERO);
          rem_next     = is_solid ? cnt : (cnt >> 1);
          if (start != p) begin
            run_pending_next = 1'b1;
            state_next       = ST_LIT_HDR;
          end else begin
            state_next = is_solid ? ST_RUN_SOLID : ST_PAT_0;
          end
        end
      end
      ST_LIT_HDR: begin
        cd_we      = 1'b1;
        cd_wdata   = LIT_TAG;
        state_next = ST_LIT_CNT;
      end
      ST_LIT_CNT: begin
        cd_we      = 1'b1;
        cd_wdata   = {1'b0, lit_chunk};
        k_next     = lit_chunk;
        state_next = ST_LIT_RD;
      end
      ST_LIT_RD: begin
        ls_raddr   = start[IW-1:0];
        state_next = ST_LIT_WR;
      end
      ST_LIT_WR: begin
        cd_we      = 1'b1;
        cd_wdata   = ls_q;
        start_next = start + 1'b1;
        k_next     = k - 1'b1;
        if (k != 7'd1) begin
          state_next = ST_LIT_RD;
        end else if (lit_left != LW'(1)) begin
          state_next = ST_LIT_HDR;
        end else begin
          run_pending_next = 1'b0;
          if (!run_pending) begin
            state_next = ST_PEND;
          end else begin
            state_next = is_pat ? ST_PAT_0 : ST_RUN_SOLID;
          end
        end
      end
      ST_RUN_SOLID: begin
        cd_we = 1'b1;
        if (rem_big) begin
          cd_wdata = is_zero ? {1'b0, RUN_MAX} : SOLID_ONES;
          rem_next = LW'(XW'(rem) - XW'(RUN_MAX));
          p_next   = LW'(XW'(p) + XW'(RUN_MAX));
        end else begin
          cd_wdata   = {!is_zero, rem_chunk};
          p_next     = p + rem;
          start_next = p + rem;
          rem_next   = '0;
          state_next = ST_TOP;
        end
      end
      ST_PAT_0: begin
        cd_we      = 1'b1;
        cd_wdata   = PAT_TAG;
        state_next = ST_PAT_N;
      end
      ST_PAT_N: begin
        cd_we      = 1'b1;
        cd_wdata   = {1'b0, rem_chunk};
        state_next = ST_PAT_C1;
      end
      ST_PAT_C1: begin
        cd_we      = 1'b1;
        cd_wdata   = c1;
        state_next = ST_PAT_C2;
      end
      ST_PAT_C2: begin
        cd_we    = 1'b1;
        cd_wdata = c2;
        rem_next = LW'(XW'(rem) - XW'(rem_chunk));
        p_next   = p_pat;
        if (rem_big) begin
          state_next = ST_PAT_0;
        end else begin
          start_next = p_pat;
          state_next = ST_TOP;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase

    // Drop coded bytes past the end of the coded store
    cd_we = cd_we && room;
    if (cd_we) begin
      wr_next = wr + 1'b1;
    end
  end

`ifndef SYNTHESIS
  // The fetch stage loads the output register, so the slot must be free there
  a_fetch_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |-> !rsp_valid)
    else $error("fetch stage reached with response still held");

  // While coded bytes are pending the read pointer trails the write pointer
  a_pend_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PEND) |-> (rd < wr))
    else $error("pending phase with no coded byte left");

  // A literal byte always lies before the current scan position
  a_lit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LIT_WR) |-> (start < p))
    else $error("literal copy past scan position");

  // A run compare only follows a fetch of both pattern bytes
  a_cmp_after_pair: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (XW'(cnt) >= XW'(2)) && (XW'(p) + XW'(cnt) < XW'(len)))
    else $error("run compare out of range");
`endif

endmodule

// ===== tb/rle_stream_checker.sv =====
// Checker for the GEM IMG scanline RLE encoder: watches both channels, codes each
// scanline itself and compares every fetched byte. Depends on gem_rle_pkg.
`timescale 1ns / 100ps

module rle_stream_checker
  import gem_rle_pkg::*;
#(
  parameter int LINE_MAX = LINE_BYTES_MAX_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending,
  output int   lines_coded,
  output int   rsp_checked,
  output int   empty_fetches
);

  localparam int         CODED_CAP    = LINE_MAX + 2 * (LINE_MAX / 127) + 8;
  localparam int         REPORT_LIMIT = 10;
  localparam logic [7:0] ONES_FLAG    = 8'h80;

  logic [7:0]  line_buf [LINE_MAX];
  int unsigned line_len;
  int unsigned read_pos;
  bit          coded_pending;
  logic [7:0]  coded_q [$];
  rsp_t        expected_q [$];
  int          errors, checked, lines, empties;

  function automatic void put_code(input logic [7:0] b);
    if (coded_q.size() < CODED_CAP) coded_q.push_back(b);
  endfunction

  // Length of the longest run starting at p, 0 when none qualifies
  function automatic int unsigned run_length_at(input int unsigned p);
    int unsigned span, i;
    logic [7:0]  c;
    span = line_len - p;
    i = 0;
    c = line_buf[p];
    while (i < span) begin
      if (line_buf[p + i] != line_buf[p + (i & 1)]) break;
      i++;
    end
    if (i < SOLID_MIN) return 0;
    if ((c != SOLID_ZERO && c != SOLID_ONES) || line_buf[p + 1] != c) begin
      i = i & 32'hFFFF_FFFE;
      if (i < PAT_MIN) i = 0;
    end
    return i;
  endfunction

  function automatic void literal_codes(input int unsigned from, input int unsigned upto);
    int unsigned n, k;
    n = upto - from;
    if (n == 0) return;
    while (n > RUN_MAX) begin
      put_code(LIT_TAG);
      put_code({1'b0, RUN_MAX});
      for (k = 0; k < RUN_MAX; k++) begin
        put_code(line_buf[from]);
        from++;
      end
      n -= RUN_MAX;
    end
    put_code(LIT_TAG);
    put_code(n[7:0]);
    while (from < upto) begin
      put_code(line_buf[from]);
      from++;
    end
  endfunction

  function automatic void run_codes(input int unsigned p, input int unsigned n);
    logic [7:0] c1, c2;
    c1 = line_buf[p];
    c2 = line_buf[p + 1];
    if (c1 == SOLID_ZERO && c2 == SOLID_ZERO) begin
      while (n > RUN_MAX) begin
        put_code({1'b0, RUN_MAX});
        n -= RUN_MAX;
      end
      put_code(n[7:0]);
    end else if (c1 == SOLID_ONES && c2 == SOLID_ONES) begin
      while (n > RUN_MAX) begin
        put_code(SOLID_ONES);
        n -= RUN_MAX;
      end
      put_code(ONES_FLAG | n[7:0]);
    end else begin
      n = n >> 1;
      while (n > RUN_MAX) begin
        put_code(PAT_TAG);
        put_code({1'b0, RUN_MAX});
        put_code(c1);
        put_code(c2);
        n -= RUN_MAX;
      end
      put_code(PAT_TAG);
      put_code(n[7:0]);
      put_code(c1);
      put_code(c2);
    end
  endfunction

  function automatic void code_line();
    int unsigned start, p, x;
    start = 0;
    p = 0;
    coded_q.delete();
    while (p < line_len) begin
      x = run_length_at(p);
      if (x != 0) begin
        literal_codes(start, p);
        run_codes(p, x);
        p += x;
        start = p;
      end else begin
        p++;
      end
    end
    literal_codes(start, p);
  endfunction

  function automatic void clear_line();
    coded_pending = 1'b0;
    line_len = 0;
    read_pos = 0;
    coded_q.delete();
  endfunction

  function automatic void take_push(input logic [7:0] data, input logic last);
    // a push drops any coded bytes still pending
    if (coded_pending) clear_line();
    if (line_len < LINE_MAX) begin
      line_buf[line_len] = data;
      line_len++;
    end
    if (last) begin
      code_line();
      read_pos = 0;
      coded_pending = 1'b1;
      lines++;
    end
  endfunction

  function automatic rsp_t next_fetch_result();
    rsp_t r;
    bit   eol;
    if (coded_pending && read_pos < coded_q.size()) begin
      eol = (read_pos + 1 == coded_q.size());
      r.out_byte = coded_q[read_pos];
      r.end_of_line = eol;
      r.nothing_ready = 1'b0;
      read_pos++;
      if (eol) clear_line();
    end else begin
      r = '0;
      r.nothing_ready = 1'b1;
      empties++;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      clear_line();
      expected_q.delete();
      errors = 0;
      checked = 0;
      lines = 0;
      empties = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        checked++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: unexpected response out_byte=%02h eol=%0b none=%0b", $realtime,
                     rsp.out_byte, rsp.end_of_line, rsp.nothing_ready);
        end else begin
          want = expected_q.pop_front();
          if (rsp.out_byte !== want.out_byte || rsp.end_of_line !== want.end_of_line ||
              rsp.nothing_ready !== want.nothing_ready) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("%0t: mismatch expected out_byte=%02h eol=%0b none=%0b, got %02h %0b %0b",
                       $realtime, want.out_byte, want.end_of_line, want.nothing_ready,
                       rsp.out_byte, rsp.end_of_line, rsp.nothing_ready);
          end
        end
      end
      if (req_valid && req_ready) begin
        if (req.op == OP_PUSH) take_push(req.data_byte, req.last_byte);
        else expected_q.push_back(next_fetch_result());
      end
    end
    fail_count <= errors;
    pending <= expected_q.size();
    lines_coded <= lines;
    rsp_checked <= checked;
    empty_fetches <= empties;
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the GEM IMG scanline RLE encoder testbench: clock, reset, request stimulus and
// response back-pressure. Depends on gem_rle_pkg, the encoder and rle_stream_checker.
`timescale 1ns / 100ps

module testbench;
  import gem_rle_pkg::*;

  localparam int TOTAL_REQUESTS = 2000;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int fail_count, pending, lines_coded, rsp_checked, empty_fetches;
  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  int requests_sent = 0;
  int eol_seen = 0;
  int cycle_count = 0;
  logic hold_trig = 1'b0;
  logic hold_ack = 1'b0;
  int hold_left = 0;
  logic [7:0] row_data [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gem_img_scanline_rle_encoder_unit dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  rle_stream_checker stream_check (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .fail_count(fail_count),
    .pending(pending),
    .lines_coded(lines_coded),
    .rsp_checked(rsp_checked),
    .empty_fetches(empty_fetches)
  );

  // Receiver: random stalls, plus a long hold-off each time hold_trig toggles
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_trig != hold_ack) begin
      rsp_ready <= 1'b0;
      hold_ack <= hold_trig;
      hold_left <= HOLD_CYCLES;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rsp_valid && rsp_ready && rsp.end_of_line) eol_seen <= eol_seen + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one request and hold it until taken; valid stays up for a back-to-back request
  task automatic send_request(input req_t item);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    requests_sent++;
  endtask

  task automatic push_byte(input logic [7:0] data, input logic last);
    req_t item;
    item.op = OP_PUSH;
    item.data_byte = data;
    item.last_byte = last;
    send_request(item);
  endtask

  task automatic fetch_once();
    req_t item;
    item.op = OP_FETCH;
    item.data_byte = 8'($urandom);
    item.last_byte = 1'($urandom);
    send_request(item);
  endtask

  task automatic random_request();
    req_t item;
    item.op = 1'($urandom);
    item.data_byte = 8'($urandom);
    item.last_byte = 1'($urandom);
    send_request(item);
  endtask

  task automatic push_line();
    for (int i = 0; i < row_data.size(); i++)
      push_byte(row_data[i], i == row_data.size() - 1);
  endtask

  // Fetch until the end of the line shows up, bounded by the largest coded size
  task automatic drain_line();
    int mark, n, cap;
    mark = eol_seen;
    n = 0;
    cap = row_data.size() + 2 * (row_data.size() / 127) + 10;
    while (eol_seen == mark && n < cap) begin
      fetch_once();
      n++;
    end
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic build_line(input int target);
    int len;
    logic [7:0] b1, b2;
    row_data.delete();
    while (row_data.size() < target) begin
      case ($urandom_range(3))
        0: begin
          len = $urandom_range(1, 6);
          repeat (len) row_data.push_back(8'($urandom));
        end
        1: begin
          b1 = $urandom_range(1) ? SOLID_ONES : SOLID_ZERO;
          len = $urandom_range(1, 10);
          repeat (len) row_data.push_back(b1);
        end
        2: begin
          b1 = 8'($urandom);
          b2 = ($urandom_range(3) == 0) ? b1 : 8'($urandom);
          len = $urandom_range(2, 16);
          for (int i = 0; i < len; i++) row_data.push_back(i[0] ? b2 : b1);
        end
        default: begin
          // near-misses built from a small alphabet
          len = $urandom_range(1, 6);
          repeat (len) begin
            case ($urandom_range(3))
              0: row_data.push_back(SOLID_ZERO);
              1: row_data.push_back(SOLID_ONES);
              2: row_data.push_back(8'h55);
              default: row_data.push_back(8'hAA);
            endcase
          end
        end
      endcase
    end
    while (row_data.size() > target) void'(row_data.pop_back());
  endtask

  function automatic int pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return $urandom_range(1, 24);
    if (roll < 95) return $urandom_range(25, 64);
    return $urandom_range(65, 127);
  endfunction

  initial begin
    int phase, kind;
    logic [7:0] b1, b2;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: fetch while loading, one-byte line and a fetch past its end,
    // one run of each kind, then a push that drops a partly read line
    fetch_once();
    push_byte(8'h7F, 1'b1);
    repeat (4) fetch_once();
    row_data = {8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA};
    push_line();
    repeat (3) fetch_once();
    push_byte(8'h80, 1'b1);
    repeat (3) fetch_once();
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
        1: begin send_idle_pct = 83; rsp_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct <= 83; end
        default: begin send_idle_pct = 9; rsp_stall_pct <= 9; end
      endcase

      case (phase)
        0: begin
          // hold the receiver off while fetches keep coming
          hold_trig <= ~hold_trig;
          build_line(16);
          push_line();
          drain_line();
        end
        1: begin
          // full line of one byte pair: pattern records split at 127 pairs
          b1 = 8'($urandom);
          b2 = 8'($urandom);
          row_data.delete();
          for (int i = 0; i < LINE_BYTES_MAX_DEF; i++) row_data.push_back(i[0] ? b2 : b1);
          push_line();
          drain_line();
        end
        2: begin
          // overfull line: long solid runs, extra bytes dropped, last one still closes
          row_data.delete();
          repeat (128) row_data.push_back(SOLID_ZERO);
          repeat (128) row_data.push_back(SOLID_ONES);
          repeat (8) row_data.push_back(8'($urandom));
          push_line();
          drain_line();
        end
        default: begin
          // literal string longer than one record
          row_data.delete();
          for (int i = 0; i < 135; i++) row_data.push_back(8'(i * 37 + 1));
          push_line();
          drain_line();
        end
      endcase

      while (requests_sent < (phase + 1) * TOTAL_REQUESTS / 4) begin
        kind = $urandom_range(99);
        if (kind < 70) begin
          build_line(pick_length());
          push_line();
          drain_line();
          if ($urandom_range(9) == 0) fetch_once();
        end else if (kind < 82) begin
          // read part of a line, then let the next push drop the rest
          build_line(pick_length());
          push_line();
          repeat ($urandom_range(0, 4)) fetch_once();
        end else if (kind < 90) begin
          // fetch in the middle of loading
          repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
          fetch_once();
        end else begin
          repeat ($urandom_range(1, 6)) random_request();
        end
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d requests, %0d coded scanlines, %0d responses (%0d empty fetches)",
             requests_sent, lines_coded, rsp_checked, empty_fetches);
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/gem_rle_pkg.sv
design/gem_img_scanline_rle_encoder_unit.sv
tb/rle_stream_checker.sv
tb/testbench.sv
